FILE: rtl/core/tkst_pkg.sv
`timescale 1ns / 1ps
package tkst_pkg;

    localparam int THREAD_SLOTS_DEF = 64;
    localparam int KEY_COUNT_DEF    = 32;

    typedef enum logic [2:0] {
        KIND_CREATE = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_GET    = 3'd2,
        KIND_SET    = 3'd3,
        KIND_FINISH = 3'd4,
        KIND_JOIN   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_KEY = 2'd1,
        ST_NO_KEY  = 2'd2,
        ST_NO_SLOT = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] thread_id;
        logic [5:0]  key_index;
        logic [63:0] data_word;
        logic [63:0] handler;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  key_out;
        logic [63:0] word_out;
        logic [63:0] handler_out;
        logic        is_destructor_call;
        logic        last;
    } rsp_t;

    // slot search request from the sequencer to the search unit
    typedef struct packed {
        logic        start;
        logic [63:0] tid;
    } srch_req_t;

endpackage

FILE: rtl/core/tkst_slot_search.sv
`timescale 1ns / 1ps
module tkst_slot_search
    import tkst_pkg::*;
#(
    parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
    localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  srch_req_t       req,
    // owner table read port, data registered by the caller
    output logic [SW-1:0]   rd_addr,
    input  logic [63:0]     rd_data,
    output logic            done,
    output logic            hit,
    output logic            free_found,
    output logic [SW-1:0]   hit_slot,
    output logic [SW-1:0]   free_slot
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_DONE} state_t;

    state_t             state_reg, state_next;
    logic [SW:0]        idx_reg, idx_next;
    logic [SW-1:0]      cmp_reg, cmp_next;
    logic [63:0]        tid_reg, tid_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic [SW-1:0]      hslot_reg, hslot_next;
    logic [SW-1:0]      fslot_reg, fslot_next;

    assign rd_addr    = idx_reg[SW-1:0];
    assign done       = (state_reg == S_DONE);
    assign hit        = hit_reg;
    assign free_found = free_reg;
    assign hit_slot   = hslot_reg;
    assign free_slot  = fslot_reg;

    // walks the owner table slot by slot, reading and then comparing each entry
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmp_next   = cmp_reg;
        tid_next   = tid_reg;
        hit_next   = hit_reg;
        free_next  = free_reg;
        hslot_next = hslot_reg;
        fslot_next = fslot_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    tid_next   = req.tid;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = (req.tid == 64'd0) ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                cmp_next   = idx_reg[SW-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_data == tid_reg)
                begin
                    hit_next   = 1'b1;
                    hslot_next = cmp_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    if (!free_reg && rd_data == 64'd0)
                    begin
                        free_next  = 1'b1;
                        fslot_next = cmp_reg;
                    end
                    state_next = (idx_reg == (SW+1)'(THREAD_SLOTS)) ? S_DONE : S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg   <= cmp_next;
        tid_reg   <= tid_next;
        hslot_reg <= hslot_next;
        fslot_reg <= fslot_next;
    end

endmodule

FILE: rtl/core/thread_key_storage_table.sv
`timescale 1ns / 1ps
// Thread-specific storage engine: thread slot table, key table, per-slot
// per-key value memory and per-slot exit words.
// Channels: req (valid/ready, req_t) carries one operation; rsp
// (valid/ready, rsp_t) returns results, last marks the final one.
// Each defined operation gives one result, except finish, which gives one
// destructor request per nonzero value of a live key with a destructor
// handle and then a closing result. A slot lookup for get, set, finish and
// join walks the owner table slot by slot, reading and then comparing each
// entry. Create scans keys one per cycle. Delete clears its column one slot
// per cycle. Finish reads and checks the slot's row key by key, and join
// clears the row at one key per cycle. The sequencer takes one operation at
// a time; req_ready is high only while it is idle, from the cycle after the
// last result of the previous operation is taken.
// Reset: after reset a clearing pass writes every entry of the value memory
// (2**(SW+KW) entries, 2048 with the default sizes) and the owner/exit
// tables, one value entry each cycle; no operation is accepted meanwhile.
// A stalled receiver holds the result register; the sequencer waits until
// each result, destructor requests included, is taken before it goes on.
module thread_key_storage_table
    import tkst_pkg::*;
#(
    parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
    parameter int KEY_COUNT    = KEY_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int AW = SW + KW;
    localparam int MD = 1 << AW;

    typedef enum logic [3:0] {
        M_CLEAR, M_IDLE, M_CREATE, M_DELETE, M_SEARCH, M_ACCESS, M_GETRD,
        M_FIN_RD, M_FIN_CHK, M_JOIN_CLR, M_RESULT, M_WAIT
    } state_t;

    state_t           state_reg, state_next;
    req_t             op_reg, op_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rvalid_reg, rvalid_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic             done_after_reg, done_after_next;

    // key table in flip-flops, read at a sequencer-chosen index
    logic [KEY_COUNT-1:0] key_in_use_reg;
    logic [63:0]          key_dtor [KEY_COUNT];

    // memories
    logic [63:0] owner_mem [THREAD_SLOTS];
    logic [63:0] exit_mem  [THREAD_SLOTS];
    logic [63:0] val_mem   [MD];
    logic [63:0] owner_q, exit_q, val_q;

    // memory port controls
    logic [SW-1:0] own_raddr, own_waddr, exit_addr;
    logic          own_we, exit_we;
    logic [63:0]   own_wdata, exit_wdata;
    logic [AW-1:0] val_addr;
    logic          val_we;
    logic [63:0]   val_wdata;
    logic          key_set, key_clr;
    logic [KW-1:0] key_waddr;

    // search unit
    srch_req_t     sreq;
    logic [SW-1:0] s_addr, s_hit_slot, s_free_slot;
    logic          s_done, s_hit, s_free;

    tkst_slot_search #(.THREAD_SLOTS(THREAD_SLOTS)) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (sreq),
        .rd_addr    (s_addr),
        .rd_data    (owner_q),
        .done       (s_done),
        .hit        (s_hit),
        .free_found (s_free),
        .hit_slot   (s_hit_slot),
        .free_slot  (s_free_slot)
    );

    logic          key_valid;
    logic [KW-1:0] op_key;
    logic [KW-1:0] cnt_key;
    logic [SW-1:0] cnt_slot;

    assign op_key    = op_reg.key_index[KW-1:0];
    assign key_valid = (32'(op_reg.key_index) < KEY_COUNT) && key_in_use_reg[op_key];
    assign cnt_key   = cnt_reg[KW-1:0];
    assign cnt_slot  = cnt_reg[SW-1:0];

    assign req_ready = (state_reg == M_IDLE);
    assign rsp_valid = rvalid_reg;
    assign rsp       = rsp_reg;

    function automatic rsp_t mk(input status_t st, input logic [4:0] k,
                                input logic [63:0] w, input logic [63:0] h,
                                input logic d, input logic l);
        rsp_t r;
        r.status = st; r.key_out = k; r.word_out = w; r.handler_out = h;
        r.is_destructor_call = d; r.last = l;
        return r;
    endfunction

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        rsp_next        = rsp_reg;
        rvalid_next     = rvalid_reg;
        cnt_next        = cnt_reg;
        slot_next       = slot_reg;
        done_after_next = done_after_reg;
        sreq.start      = 1'b0;
        sreq.tid        = op_reg.thread_id;
        own_raddr       = s_addr;
        own_we          = 1'b0;
        own_waddr       = slot_reg;
        own_wdata       = op_reg.thread_id;
        exit_addr       = slot_reg;
        exit_we         = 1'b0;
        exit_wdata      = op_reg.data_word;
        val_addr        = {slot_reg, op_key};
        val_we          = 1'b0;
        val_wdata       = 64'd0;
        key_set         = 1'b0;
        key_clr         = 1'b0;
        key_waddr       = op_key;

        if (rvalid_reg && rsp_ready)
            rvalid_next = 1'b0;

        unique case (state_reg)
            M_CLEAR:
            begin
                val_we    = 1'b1;
                val_addr  = cnt_reg[AW-1:0];
                own_we    = (cnt_reg[KW-1:0] == '0) || (KEY_COUNT == 1);
                own_waddr = cnt_reg[AW-1:KW];
                own_wdata = 64'd0;
                exit_we   = own_we;
                exit_addr = cnt_reg[AW-1:KW];
                exit_wdata = 64'd0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(MD - 1))
                    state_next = M_IDLE;
            end
            M_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req;
                    cnt_next = '0;
                    unique case (req.kind)
                        KIND_CREATE: state_next = M_CREATE;
                        KIND_DELETE, KIND_GET, KIND_SET, KIND_FINISH, KIND_JOIN:
                            state_next = M_DELETE;
                        default: state_next = M_IDLE;
                    endcase
                end
            end
            M_CREATE:
            begin
                // scan keys for the first free one
                if (!key_in_use_reg[cnt_key])
                begin
                    key_set   = 1'b1;
                    key_waddr = cnt_key;
                    rsp_next  = mk(ST_OK, 5'(cnt_key), 64'd0, 64'd0, 1'b0, 1'b1);
                    state_next = M_RESULT;
                end
                else if (cnt_reg == (AW+1)'(KEY_COUNT - 1))
                begin
                    rsp_next   = mk(ST_NO_KEY, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                    state_next = M_RESULT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            M_DELETE:
            begin
                // dispatch point: key check for delete, get and set, then column clear or slot search
                if (op_reg.kind == KIND_DELETE)
                begin
                    if (!key_valid && cnt_reg == '0)
                    begin
                        rsp_next   = mk(ST_BAD_KEY, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                        state_next = M_RESULT;
                    end
                    else
                    begin
                        key_clr  = 1'b1;
                        val_we   = 1'b1;
                        val_addr = {cnt_slot, op_key};
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == (AW+1)'(THREAD_SLOTS - 1))
                        begin
                            rsp_next   = mk(ST_OK, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                            state_next = M_RESULT;
                        end
                    end
                end
                else if ((op_reg.kind == KIND_GET || op_reg.kind == KIND_SET) && !key_valid)
                begin
                    rsp_next   = mk(ST_BAD_KEY, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                    state_next = M_RESULT;
                end
                else
                begin
                    sreq.start = 1'b1;
                    state_next = M_SEARCH;
                end
            end
            M_SEARCH:
            begin
                if (s_done)
                begin
                    if (s_hit)
                    begin
                        slot_next  = s_hit_slot;
                        state_next = M_ACCESS;
                    end
                    else if (op_reg.kind == KIND_JOIN)
                    begin
                        rsp_next   = mk(ST_OK, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                        state_next = M_RESULT;
                    end
                    else if (s_free)
                    begin
                        slot_next  = s_free_slot;
                        own_we     = 1'b1;
                        own_waddr  = s_free_slot;
                        state_next = M_ACCESS;
                    end
                    else
                    begin
                        rsp_next   = mk(ST_NO_SLOT, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                        state_next = M_RESULT;
                    end
                end
            end
            M_ACCESS:
            begin
                cnt_next = '0;
                unique case (op_reg.kind)
                    KIND_SET:
                    begin
                        val_we     = 1'b1;
                        val_wdata  = op_reg.data_word;
                        rsp_next   = mk(ST_OK, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                        state_next = M_RESULT;
                    end
                    KIND_FINISH:
                    begin
                        exit_we    = 1'b1;
                        state_next = M_FIN_RD;
                    end
                    KIND_JOIN:
                    begin
                        // exit word read is issued here
                        state_next = M_GETRD;
                    end
                    default:
                    begin
                        state_next = M_GETRD;
                    end
                endcase
            end
            M_GETRD:
            begin
                if (op_reg.kind == KIND_JOIN)
                begin
                    rsp_next   = mk(ST_OK, 5'd0, exit_q, 64'd0, 1'b0, 1'b1);
                    exit_we    = 1'b1;
                    exit_wdata = 64'd0;
                    own_we     = 1'b1;
                    own_wdata  = 64'd0;
                    state_next = M_JOIN_CLR;
                end
                else
                begin
                    rsp_next   = mk(ST_OK, 5'd0, val_q, 64'd0, 1'b0, 1'b1);
                    state_next = M_RESULT;
                end
            end
            M_JOIN_CLR:
            begin
                val_we   = 1'b1;
                val_addr = {slot_reg, cnt_key};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(KEY_COUNT - 1))
                    state_next = M_RESULT;
            end
            M_FIN_RD:
            begin
                // read the row entry, checked next cycle
                val_addr   = {slot_reg, cnt_key};
                state_next = M_FIN_CHK;
            end
            M_FIN_CHK:
            begin
                done_after_next = (cnt_reg == (AW+1)'(KEY_COUNT - 1));
                val_we   = 1'b1;
                val_addr = {slot_reg, cnt_key};
                cnt_next = cnt_reg + 1'b1;
                if (val_q != 64'd0 && key_in_use_reg[cnt_key] && key_dtor[cnt_key] != 64'd0)
                begin
                    rsp_next   = mk(ST_OK, 5'(cnt_key), val_q, key_dtor[cnt_key], 1'b1, 1'b0);
                    state_next = M_RESULT;
                end
                else if (cnt_reg == (AW+1)'(KEY_COUNT - 1))
                begin
                    rsp_next   = mk(ST_OK, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                    state_next = M_RESULT;
                end
                else
                    state_next = M_FIN_RD;
            end
            M_RESULT:
            begin
                // present the result held in the result register
                if (!rvalid_reg || rsp_ready)
                begin
                    rvalid_next = 1'b1;
                    state_next  = M_WAIT;
                end
            end
            M_WAIT:
            begin
                // continue only once the presented result is taken
                if (!rvalid_reg || rsp_ready)
                begin
                    if (rsp_reg.last)
                        state_next = M_IDLE;
                    else if (done_after_reg)
                    begin
                        // closing result after the final destructor request
                        rsp_next        = mk(ST_OK, 5'd0, 64'd0, 64'd0, 1'b0, 1'b1);
                        done_after_next = 1'b0;
                        state_next      = M_RESULT;
                    end
                    else
                        state_next = M_FIN_RD;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= M_CLEAR;
            rvalid_reg     <= 1'b0;
            cnt_reg        <= '0;
            done_after_reg <= 1'b0;
            key_in_use_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rvalid_reg     <= rvalid_next;
            cnt_reg        <= cnt_next;
            done_after_reg <= done_after_next;
            if (key_set)
                key_in_use_reg[key_waddr] <= 1'b1;
            else if (key_clr)
                key_in_use_reg[key_waddr] <= 1'b0;
        end
    end

    // payload registers and key handles
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rsp_reg  <= rsp_next;
        slot_reg <= slot_next;
        if (key_set)
            key_dtor[key_waddr] <= op_reg.handler;
    end

    // memories with registered reads
    always_ff @(posedge clk)
    begin
        if (own_we)
            owner_mem[own_waddr] <= own_wdata;
        owner_q <= owner_mem[own_raddr];
        if (exit_we)
            exit_mem[exit_addr] <= exit_wdata;
        exit_q <= exit_mem[exit_addr];
        if (val_we)
            val_mem[val_addr] <= val_wdata;
        val_q <= val_mem[val_addr];
    end

endmodule

FILE: rtl/core/tkst_checker.sv
`timescale 1ns / 1ps
module tkst_checker
    import tkst_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input rsp_t rsp,
    input logic rsp_valid,
    input logic rsp_ready
);

    // result held while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // no new transaction while a result is waiting
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(req_valid && req_ready))
        else $error("accepting while result pending");

    // destructor requests never close an item
    a_dtor_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_destructor_call |-> !rsp.last)
        else $error("destructor result marked last");

    // no handle outside destructor requests
    a_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_destructor_call |-> rsp.handler_out == 64'd0)
        else $error("stray handle");

endmodule

bind thread_key_storage_table tkst_checker u_tkst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
);
